>>> sv/hsv_priority_color_classifier_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the HSV priority color classifier.
// Each macro holds a concurrent assertion that reports with $error.
// ---------------------------------------------------------------------------
`ifndef HSV_PRIORITY_COLOR_CLASSIFIER_TOP_ASSERT_SVH
`define HSV_PRIORITY_COLOR_CLASSIFIER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define HPCC_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HPCC_ASSERT_ANY(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HPCC_ASSERT_RST(label, clk, rst_n, prop, msg)
`define HPCC_ASSERT_ANY(label, clk, prop, msg)
`endif
`endif

>>> sv/hpcc_pkg.sv
// ---------------------------------------------------------------------------
// hpcc_pkg
// Types, label codes and the false color table of the classifier.
// ---------------------------------------------------------------------------
package hpcc_pkg;

	localparam int NUM_BOXES = 8;
	localparam int QBITS     = 8;

	localparam logic [3:0] LABEL_NONE   = 4'd0;
	localparam logic [3:0] LABEL_YELLOW = 4'd1;
	localparam logic [3:0] LABEL_BLUE   = 4'd2;
	localparam logic [3:0] LABEL_ORANGE = 4'd3;
	localparam logic [3:0] LABEL_GREEN  = 4'd4;
	localparam logic [3:0] LABEL_WHITE  = 4'd5;
	localparam logic [3:0] LABEL_BLACK  = 4'd6;
	localparam logic [3:0] LABEL_RED    = 4'd7;
	localparam logic [3:0] LABEL_OTHER  = 4'd8;

	typedef struct packed {
		logic [16:0] h_num;
		logic [8:0]  h_den;
		logic [15:0] s_num;
		logic [7:0]  s_den;
		logic [7:0]  val;
		logic        gray;
		logic        black;
	} front_t;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] sat;
		logic [7:0] val;
		logic       black;
	} hsv_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	function automatic rgb_t color_of(input logic [3:0] label);
		rgb_t c;
		case (label)
			LABEL_YELLOW: c = '{blue: 8'd128, green: 8'd128, red: 8'd0};
			LABEL_BLUE:   c = '{blue: 8'd128, green: 8'd0,   red: 8'd128};
			LABEL_ORANGE: c = '{blue: 8'd128, green: 8'd0,   red: 8'd0};
			LABEL_GREEN:  c = '{blue: 8'd0,   green: 8'd0,   red: 8'd128};
			LABEL_WHITE:  c = '{blue: 8'd0,   green: 8'd255, red: 8'd255};
			LABEL_BLACK:  c = '{blue: 8'd255, green: 8'd0,   red: 8'd255};
			LABEL_RED:    c = '{blue: 8'd255, green: 8'd255, red: 8'd0};
			LABEL_OTHER:  c = '{blue: 8'd255, green: 8'd0,   red: 8'd128};
			default:      c = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
		endcase
		return c;
	endfunction

endpackage

>>> sv/hpcc_front.sv
// ---------------------------------------------------------------------------
// hpcc_front
// First stage: extremes, chroma and the dividends and divisors of S and H.
// ---------------------------------------------------------------------------
module hpcc_front import hpcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	output logic        out_valid,
	output front_t      out_data
);

	logic [7:0]  mx, mn, d;
	logic [10:0] n, d11;
	front_t      f;
	logic        valid_s1;
	front_t      data_s1;

	always_comb begin
		mx = in_red;
		if (in_green > mx) mx = in_green;
		if (in_blue > mx) mx = in_blue;
		mn = in_red;
		if (in_green < mn) mn = in_green;
		if (in_blue < mn) mn = in_blue;
		d = mx - mn;
		d11 = {3'd0, d};
		if (mx == in_red) begin
			if (in_green >= in_blue) n = {3'd0, in_green} - {3'd0, in_blue};
			else n = 11'(6 * d11) - ({3'd0, in_blue} - {3'd0, in_green});
		end else if (mx == in_green) begin
			n = 11'(2 * d11) + {3'd0, in_blue} - {3'd0, in_red};
		end else begin
			n = 11'(4 * d11) + {3'd0, in_red} - {3'd0, in_green};
		end
		f.h_num = 17'({6'd0, n} * 17'd85);
		f.h_den = {d, 1'b0};
		f.s_num = 16'({8'd0, d} * 16'd255);
		f.s_den = mx;
		f.val   = mx;
		f.gray  = (d == 8'd0);
		f.black = (mx == 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= f;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

>>> sv/hpcc_div_pipe.sv
// ---------------------------------------------------------------------------
// hpcc_div_pipe
// Two restoring dividers side by side, one quotient bit per stage.
// ---------------------------------------------------------------------------
module hpcc_div_pipe import hpcc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  front_t in_data,
	output logic   out_valid,
	output hsv_t   out_data
);

	logic        valid_s [QBITS+1];
	logic [16:0] h_rem_s [QBITS+1];
	logic [8:0]  h_den_s [QBITS+1];
	logic [15:0] s_rem_s [QBITS+1];
	logic [7:0]  s_den_s [QBITS+1];
	logic [7:0]  h_q_s   [QBITS+1];
	logic [7:0]  s_q_s   [QBITS+1];
	logic [7:0]  val_s   [QBITS+1];
	logic        gray_s  [QBITS+1];
	logic        black_s [QBITS+1];

	assign valid_s[0] = in_valid;
	assign h_rem_s[0] = in_data.h_num;
	assign h_den_s[0] = in_data.h_den;
	assign s_rem_s[0] = in_data.s_num;
	assign s_den_s[0] = in_data.s_den;
	assign h_q_s[0]   = 8'd0;
	assign s_q_s[0]   = 8'd0;
	assign val_s[0]   = in_data.val;
	assign gray_s[0]  = in_data.gray;
	assign black_s[0] = in_data.black;

	for (genvar k = 0; k < QBITS; k++) begin : g_stage
		localparam int B = QBITS - 1 - k;
		logic [16:0] h_sub;
		logic [15:0] s_sub;
		logic        h_take, s_take;

		assign h_sub  = {8'd0, h_den_s[k]} << B;
		assign s_sub  = {8'd0, s_den_s[k]} << B;
		assign h_take = (h_rem_s[k] >= h_sub);
		assign s_take = (s_rem_s[k] >= s_sub);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				h_rem_s[k+1] <= h_take ? h_rem_s[k] - h_sub : h_rem_s[k];
				s_rem_s[k+1] <= s_take ? s_rem_s[k] - s_sub : s_rem_s[k];
				h_q_s[k+1]   <= h_q_s[k] | (8'(h_take) << B);
				s_q_s[k+1]   <= s_q_s[k] | (8'(s_take) << B);
				h_den_s[k+1] <= h_den_s[k];
				s_den_s[k+1] <= s_den_s[k];
				val_s[k+1]   <= val_s[k];
				gray_s[k+1]  <= gray_s[k];
				black_s[k+1] <= black_s[k];
			end
		end
	end

	// A gray pixel has hue 0, and a black pixel has saturation 0.
	assign out_valid      = valid_s[QBITS];
	assign out_data.hue   = gray_s[QBITS] ? 8'd0 : h_q_s[QBITS];
	assign out_data.sat   = black_s[QBITS] ? 8'd0 : s_q_s[QBITS];
	assign out_data.val   = val_s[QBITS];
	assign out_data.black = black_s[QBITS];

endmodule

>>> sv/hpcc_classify.sv
// ---------------------------------------------------------------------------
// hpcc_classify
// Last stage: box tests in priority order, label and false color register.
// ---------------------------------------------------------------------------
module hpcc_classify import hpcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  hsv_t        in_data,
	input  logic [47:0] boxes [NUM_BOXES],
	output logic        out_valid,
	output logic [3:0]  out_label,
	output rgb_t        out_color
);

	logic [NUM_BOXES-1:0] hit;
	logic [3:0]           label;
	logic                 valid_s10;
	logic [3:0]           label_s10;
	rgb_t                 color_s10;

	always_comb begin
		for (int i = 0; i < NUM_BOXES; i++) begin
			logic [7:0] hmin, hmax, smin, smax, vmin, vmax;
			logic       hue_ok;
			hmin = boxes[i][7:0];
			hmax = boxes[i][15:8];
			smin = boxes[i][23:16];
			smax = boxes[i][31:24];
			vmin = boxes[i][39:32];
			vmax = boxes[i][47:40];
			if (hmax >= hmin) hue_ok = (in_data.hue >= hmin) && (in_data.hue <= hmax);
			else hue_ok = (in_data.hue <= hmax) || (in_data.hue >= hmin);
			hit[i] = hue_ok && (in_data.sat >= smin) && (in_data.sat <= smax)
				&& (in_data.val >= vmin) && (in_data.val <= vmax);
		end
		label = LABEL_NONE;
		if (!in_data.black) begin
			for (int i = NUM_BOXES - 1; i >= 0; i--) begin
				if (hit[i]) label = 4'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else if (en) begin
			valid_s10 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			label_s10 <= label;
			color_s10 <= color_of(label);
		end
	end

	assign out_valid = valid_s10;
	assign out_label = label_s10;
	assign out_color = color_s10;

endmodule

>>> sv/hsv_priority_color_classifier_top.sv
// ---------------------------------------------------------------------------
// hsv_priority_color_classifier_top
// RGB888 to HSV conversion and classification against eight HSV boxes.
// ---------------------------------------------------------------------------
// The slave stream takes one pixel per transfer and the master stream
// gives one label and false color per transfer, in the same order.
// The pipeline has ten register stages: one for the extremes and the
// dividends, eight for the quotient bits of hue and saturation, and one
// for the box tests and the false color.
// Throughput is one pixel per cycle while the receiver takes results.
// The configuration channel is always ready; a write at an index of
// eight or more is ignored. The user must write boxes only while the
// block idles; the block itself does not enforce this. Reset clears
// all boxes to zero and empties the pipeline. When the receiver
// stalls, the whole pipeline holds and s_axis_tready drops, so no
// pixel is lost or repeated.
// ---------------------------------------------------------------------------
`include "hsv_priority_color_classifier_top_assert.svh"
module hsv_priority_color_classifier_top import hpcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // in_red, in_green, in_blue
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // class_label, out_red, out_green, out_blue, zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	logic [47:0] box_q [NUM_BOXES];
	logic        en;
	logic        front_valid, div_valid;
	front_t      front_data;
	hsv_t        div_data;
	logic [3:0]  label;
	rgb_t        color;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BOXES; i++) box_q[i] <= 48'd0;
		end else if (cfg_valid && (cfg_index < 4'(NUM_BOXES))) begin
			box_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	hpcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.in_red    (s_axis_tdata[7:0]),
		.in_green  (s_axis_tdata[15:8]),
		.in_blue   (s_axis_tdata[23:16]),
		.out_valid (front_valid),
		.out_data  (front_data)
	);

	hpcc_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.in_data   (front_data),
		.out_valid (div_valid),
		.out_data  (div_data)
	);

	hpcc_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.in_data   (div_data),
		.boxes     (box_q),
		.out_valid (m_axis_tvalid),
		.out_label (label),
		.out_color (color)
	);

	assign m_axis_tdata = {4'd0, color.blue, color.green, color.red, label};

	`HPCC_ASSERT_RST(a_label_range, clk, arst_n, m_axis_tvalid |-> (label <= LABEL_OTHER), "label out of range")
	`HPCC_ASSERT_RST(a_none_black, clk, arst_n, (m_axis_tvalid && label == LABEL_NONE) |-> (m_axis_tdata[27:4] == 24'd0), "no label but color not black")
	`HPCC_ASSERT_ANY(a_empty_ready, clk, !m_axis_tvalid |-> s_axis_tready, "empty output but input stalled")

endmodule
